/* hdl/sed_pkg.sv */
// Shared types, codes and helper functions for the string escape decoder.
package sed_pkg;

   typedef enum logic [2:0] {
      M_IDLE   = 3'd0,
      M_ESC    = 3'd1,
      M_OCT    = 3'd2,
      M_HEX2   = 3'd3,
      M_HEX4   = 3'd4,
      M_XBRACE = 3'd5,
      M_OFIRST = 3'd6,
      M_OBRACE = 3'd7
   } mode_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNKNOWN   = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NO_BRACE  = 3'd4;
   localparam logic [2:0] ST_TRAIL_BSL = 3'd5;

   localparam logic [7:0] CH_BSL    = 8'h5c;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_X_LO   = 8'h78;
   localparam logic [7:0] CH_X_UP   = 8'h58;
   localparam logic [7:0] CH_O_LO   = 8'h6f;
   localparam logic [7:0] CH_ESCAPE = 8'h1b;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] status;
      logic       last_out;
   } result_type;

   // up to two results per request, packed from slot0
   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } dec_out_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h37);
   endfunction

endpackage

/* hdl/sed_if.sv */
// Valid/ready channel interfaces for requests and results.
interface sed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_mark;
   modport source (output valid, output char_in, output end_mark, input ready);
   modport sink   (input valid, input char_in, input end_mark, output ready);
endinterface

interface sed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] status;
   logic       last_out;
   modport source (output valid, output byte_out, output status, output last_out, input ready);
   modport sink   (input valid, input byte_out, input status, input last_out, output ready);
endinterface

/* hdl/string_escape_decoder_top.sv */
// Top level of the C string escape decoder.
//
// Requests arrive on req_if (valid/ready): one source character in char_in,
// or a terminator with end_mark set. Results leave on rsp_if (valid/ready):
// decoded byte_out, a status code and last_out on the terminator's NUL.
// A request is registered in the input stage, decoded there against the
// escape state, and its zero, one or two results enter a four-entry queue
// whose head drives rsp_if.
// Throughput: one request per cycle while results are taken; a request that
// yields two results (terminator after an open escape, or a character that
// ends a numeric escape and is itself output) sends them one after another
// through the single result port.
// Reset clears the escape state, the input stage and the queue.
// When the receiver stalls, the queue fills and req_if.ready drops once it
// cannot take two more results; no result is lost or reordered.
module string_escape_decoder_top
   import sed_pkg::*;
#(
   parameter int EXT_HEX_DIGITS = 17,
   parameter int EXT_OCT_DIGITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sed_req_if.sink   req_if,
   sed_rsp_if.source rsp_if
);

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_end_ff;
   logic        room;
   logic        advance;
   dec_out_type dec_out;

   assign advance      = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_char_ff <= req_if.char_in;
         in_end_ff  <= req_if.end_mark;
      end
   end

   sed_decode #(
      .EXT_HEX_DIGITS (EXT_HEX_DIGITS),
      .EXT_OCT_DIGITS (EXT_OCT_DIGITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .char_in  (in_char_ff),
      .end_mark (in_end_ff),
      .dec_out  (dec_out)
   );

   sed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (dec_out),
      .room      (room),
      .rsp_if    (rsp_if)
   );

endmodule

/* hdl/sed_decode.sv */
// Escape decoder: mode/value state and the per-character decode logic.
module sed_decode
   import sed_pkg::*;
#(
   parameter int EXT_HEX_DIGITS = 17,
   parameter int EXT_OCT_DIGITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  char_in,
   input  logic        end_mark,
   output dec_out_type dec_out
);

   localparam logic [4:0] HEX_LIMIT = 5'(EXT_HEX_DIGITS);
   localparam logic [4:0] OCT_LIMIT = 5'(EXT_OCT_DIGITS);

   mode_type   mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic       ovf_ff, ovf_in;
   logic [4:0] cnt_ff, cnt_in;

   digit_type  hd;
   logic [7:0] acc_hex, acc_oct;
   logic       ovf_hex, ovf_oct;
   logic [4:0] cnt_inc;
   logic       flush_v;
   result_type flush_r;
   result_type f, s;
   logic       fv, sv;

   assign hd      = hex_digit(char_in);
   assign acc_hex = {acc_ff[3:0], hd.value};
   assign ovf_hex = ovf_ff | (acc_ff[7:4] != 4'd0);
   assign acc_oct = {acc_ff[4:0], char_in[2:0]};
   assign ovf_oct = ovf_ff | (acc_ff[7:5] != 3'd0);
   assign cnt_inc = cnt_ff + 5'd1;

   // result of closing a pending escape without a proper ending character
   always_comb begin
      flush_v = 1'b1;
      flush_r = '{byte_out: acc_ff, status: (ovf_ff ? ST_TRUNC : ST_OK), last_out: 1'b0};
      case (mode_ff)
         M_IDLE: flush_v = 1'b0;
         M_ESC:  flush_r = '{byte_out: CH_BSL, status: ST_TRAIL_BSL, last_out: 1'b0};
         M_OCT:  ;
         M_HEX2, M_HEX4: begin
            if (cnt_ff == 5'd0) flush_r = '{byte_out: CH_X_LO, status: ST_EMPTY, last_out: 1'b0};
         end
         M_XBRACE: flush_r = '{byte_out: CH_X_LO,
                               status: (cnt_ff == 5'd0) ? ST_EMPTY : ST_NO_BRACE,
                               last_out: 1'b0};
         M_OFIRST: flush_r = '{byte_out: CH_O_LO, status: ST_OK, last_out: 1'b0};
         M_OBRACE: flush_r = '{byte_out: CH_O_LO,
                               status: (cnt_ff == 5'd0) ? ST_EMPTY : ST_NO_BRACE,
                               last_out: 1'b0};
         default: flush_v = 1'b0;
      endcase
   end

   always_comb begin
      logic restart;
      logic emit;
      logic [7:0] e_acc;
      logic       e_ovf;
      restart = 1'b0;
      emit    = 1'b0;
      e_acc   = acc_ff;
      e_ovf   = ovf_ff;
      mode_in = mode_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      fv      = 1'b0;
      sv      = 1'b0;
      f       = flush_r;
      s       = '{byte_out: char_in, status: ST_OK, last_out: 1'b0};

      if (end_mark) begin
         fv = flush_v;
         sv = 1'b1;
         s  = '{byte_out: 8'h00, status: ST_OK, last_out: 1'b1};
         mode_in = M_IDLE;
         acc_in  = 8'h00;
         ovf_in  = 1'b0;
         cnt_in  = 5'd0;
      end else begin
         case (mode_ff)
            M_IDLE: begin
               if (char_in == CH_BSL) mode_in = M_ESC;
               else sv = 1'b1;
            end
            M_ESC: begin
               mode_in = M_IDLE;
               acc_in  = 8'h00;
               ovf_in  = 1'b0;
               cnt_in  = 5'd0;
               sv      = 1'b1;
               case (char_in)
                  8'h61: s.byte_out = 8'h07;
                  8'h62: s.byte_out = 8'h08;
                  8'h66: s.byte_out = 8'h0c;
                  8'h6e: s.byte_out = 8'h0a;
                  8'h72: s.byte_out = 8'h0d;
                  8'h74: s.byte_out = 8'h09;
                  8'h76: s.byte_out = 8'h0b;
                  8'h65: s.byte_out = CH_ESCAPE;
                  8'h22, 8'h3f, 8'h27, CH_BSL: ;
                  CH_X_LO: begin sv = 1'b0; mode_in = M_HEX2; end
                  CH_X_UP: begin sv = 1'b0; mode_in = M_HEX4; end
                  CH_O_LO: begin sv = 1'b0; mode_in = M_OFIRST; end
                  default: begin
                     if (is_oct(char_in)) begin
                        sv      = 1'b0;
                        mode_in = M_OCT;
                        acc_in  = {5'd0, char_in[2:0]};
                        cnt_in  = 5'd1;
                     end else begin
                        s.status = ST_UNKNOWN;
                     end
                  end
               endcase
            end
            M_OCT: begin
               if (is_oct(char_in)) begin
                  acc_in = acc_oct;
                  ovf_in = ovf_oct;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= 5'd3) begin
                     emit = 1'b1; e_acc = acc_oct; e_ovf = ovf_oct;
                  end
               end else begin
                  restart = 1'b1;
               end
            end
            M_HEX2, M_HEX4: begin
               if (cnt_ff == 5'd0 && char_in == CH_LBRACE) begin
                  mode_in = M_XBRACE;
               end else if (hd.valid) begin
                  acc_in = acc_hex;
                  ovf_in = ovf_hex;
                  cnt_in = cnt_inc;
                  if (cnt_inc >= ((mode_ff == M_HEX4) ? 5'd4 : 5'd2)) begin
                     emit = 1'b1; e_acc = acc_hex; e_ovf = ovf_hex;
                  end
               end else begin
                  restart = 1'b1;
               end
            end
            M_XBRACE: begin
               if (hd.valid && cnt_ff < HEX_LIMIT) begin
                  acc_in = acc_hex;
                  ovf_in = ovf_hex;
                  cnt_in = cnt_inc;
               end else if (char_in == CH_RBRACE) begin
                  emit = 1'b1;
               end else begin
                  restart = 1'b1;
               end
            end
            M_OFIRST: begin
               if (char_in == CH_LBRACE) mode_in = M_OBRACE;
               else restart = 1'b1;
            end
            M_OBRACE: begin
               if (is_oct(char_in) && cnt_ff < OCT_LIMIT) begin
                  acc_in = acc_oct;
                  ovf_in = ovf_oct;
                  cnt_in = cnt_inc;
               end else if (char_in == CH_RBRACE) begin
                  emit = 1'b1;
               end else begin
                  restart = 1'b1;
               end
            end
            default: begin
               mode_in = M_IDLE;
               acc_in  = 8'h00;
               ovf_in  = 1'b0;
               cnt_in  = 5'd0;
               if (char_in == CH_BSL) mode_in = M_ESC;
               else sv = 1'b1;
            end
         endcase

         if (emit) begin
            fv = 1'b1;
            // closing brace with no digits gives the escape letter
            if (mode_ff == M_XBRACE && cnt_ff == 5'd0)
               f = '{byte_out: CH_X_LO, status: ST_EMPTY, last_out: 1'b0};
            else if (mode_ff == M_OBRACE && cnt_ff == 5'd0)
               f = '{byte_out: CH_O_LO, status: ST_EMPTY, last_out: 1'b0};
            else
               f = '{byte_out: e_acc, status: (e_ovf ? ST_TRUNC : ST_OK), last_out: 1'b0};
            mode_in = M_IDLE;
            acc_in  = 8'h00;
            ovf_in  = 1'b0;
            cnt_in  = 5'd0;
         end

         if (restart) begin
            fv      = flush_v;
            acc_in  = 8'h00;
            ovf_in  = 1'b0;
            cnt_in  = 5'd0;
            if (char_in == CH_BSL) mode_in = M_ESC;
            else begin
               mode_in = M_IDLE;
               sv      = 1'b1;
            end
         end
      end
   end

   always_comb begin
      dec_out.count = {1'b0, fv} + {1'b0, sv};
      dec_out.slot0 = fv ? f : s;
      dec_out.slot1 = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= 8'h00;
         ovf_ff  <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
      end
   end

   // the terminator always closes the string and leaves no escape pending
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      step && end_mark |=> mode_ff == M_IDLE && cnt_ff == 5'd0)
      else $error("escape state not cleared after terminator");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      step && end_mark |-> dec_out.count != 2'd0 &&
         ((dec_out.count == 2'd1 && dec_out.slot0.last_out) ||
          (dec_out.count == 2'd2 && dec_out.slot1.last_out && !dec_out.slot0.last_out)))
      else $error("terminator result not marked last");

endmodule

/* hdl/sed_queue.sv */
// Four-entry result queue taking up to two results per cycle.
module sed_queue
   import sed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  dec_out_type push_data,
   output logic        room,
   sed_rsp_if.source   rsp_if
);

   result_type  mem [4];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;
   logic [1:0]  push_n;

   assign pop    = rsp_if.valid && rsp_if.ready;
   assign push_n = push ? push_data.count : 2'd0;
   // two free slots after this cycle's pop
   assign room   = (count_ff - {2'd0, pop}) <= 3'd2;

   assign rsp_if.valid    = count_ff != 3'd0;
   assign rsp_if.byte_out = mem[rd_ff].byte_out;
   assign rsp_if.status   = mem[rd_ff].status;
   assign rsp_if.last_out = mem[rd_ff].last_out;

   assign wr_in    = wr_ff + push_n;
   assign rd_in    = rd_ff + {1'b0, pop};
   assign count_in = count_ff - {2'd0, pop} + {1'b0, push_n};

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem[wr_ff] <= push_data.slot0;
      if (push_n == 2'd2) mem[wr_ff + 2'd1] <= push_data.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room && (count_ff - {2'd0, pop} + {1'b0, push_n}) <= 3'd4)
      else $error("result queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4 && (count_ff[1:0] == 2'(wr_ff - rd_ff)))
      else $error("result queue pointers and count disagree");

endmodule

/* tb/decode_checker.sv */
// Scoreboard for the escape decoder: predicts decoded bytes from accepted requests and checks results.
module decode_checker #(
   parameter int EXT_HEX_DIGITS = 17,
   parameter int EXT_OCT_DIGITS = 16
) (
   input  logic clock,
   input  logic reset,
   sed_req_if   req_ch,
   sed_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sed_pkg::*;

   localparam int REPORT_LIMIT = 10;

   mode_type   esc_mode;
   logic [7:0] val;
   logic       val_ovf;
   logic [4:0] ndig;
   result_type decoded_q[$];
   int         errors = 0;

   function int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function bit is_octal(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function void expect_result(input logic [7:0] b, input logic [2:0] st, input logic lst);
      result_type r;
      r.byte_out = b;
      r.status   = st;
      r.last_out = lst;
      decoded_q.push_back(r);
   endfunction

   function void reset_escape();
      esc_mode = M_IDLE;
      val      = '0;
      val_ovf  = 1'b0;
      ndig     = '0;
   endfunction

   // bits is 3 for octal, 4 for hex; any set bit shifted out marks truncation
   function void add_digit(input int d, input int bits);
      if ((val >> (8 - bits)) != 0) val_ovf = 1'b1;
      val  = (val << bits) | d[7:0];
      ndig = ndig + 1'b1;
   endfunction

   function void emit_value();
      expect_result(val, val_ovf ? ST_TRUNC : ST_OK, 1'b0);
      reset_escape();
   endfunction

   // close a pending escape that did not get its proper ending
   function void flush_escape();
      case (esc_mode)
         M_ESC: expect_result(CH_BSL, ST_TRAIL_BSL, 1'b0);
         M_OCT: expect_result(val, val_ovf ? ST_TRUNC : ST_OK, 1'b0);
         M_HEX2, M_HEX4: begin
            if (ndig == 0) expect_result(CH_X_LO, ST_EMPTY, 1'b0);
            else expect_result(val, val_ovf ? ST_TRUNC : ST_OK, 1'b0);
         end
         M_XBRACE: expect_result(CH_X_LO, ndig == 0 ? ST_EMPTY : ST_NO_BRACE, 1'b0);
         M_OFIRST: expect_result(CH_O_LO, ST_OK, 1'b0);
         M_OBRACE: expect_result(CH_O_LO, ndig == 0 ? ST_EMPTY : ST_NO_BRACE, 1'b0);
         default: ;
      endcase
      reset_escape();
   endfunction

   function void plain_char(input logic [7:0] c);
      if (c == CH_BSL) esc_mode = M_ESC;
      else expect_result(c, ST_OK, 1'b0);
   endfunction

   function void escape_letter(input logic [7:0] c);
      reset_escape();
      case (c)
         "a": expect_result(8'h07, ST_OK, 1'b0);
         "b": expect_result(8'h08, ST_OK, 1'b0);
         "f": expect_result(8'h0c, ST_OK, 1'b0);
         "n": expect_result(8'h0a, ST_OK, 1'b0);
         "r": expect_result(8'h0d, ST_OK, 1'b0);
         "t": expect_result(8'h09, ST_OK, 1'b0);
         "v": expect_result(8'h0b, ST_OK, 1'b0);
         "e": expect_result(CH_ESCAPE, ST_OK, 1'b0);
         "\"", "?", "'", CH_BSL: expect_result(c, ST_OK, 1'b0);
         CH_X_LO: esc_mode = M_HEX2;
         CH_X_UP: esc_mode = M_HEX4;
         CH_O_LO: esc_mode = M_OFIRST;
         default: begin
            if (is_octal(c)) begin
               esc_mode = M_OCT;
               val      = c - "0";
               ndig     = 5'd1;
            end else begin
               expect_result(c, ST_UNKNOWN, 1'b0);
            end
         end
      endcase
   endfunction

   function void decode_request(input logic [7:0] c, input logic endm);
      int h;
      h = hex_value(c);
      if (endm) begin
         flush_escape();
         expect_result(8'h00, ST_OK, 1'b1);
         return;
      end
      case (esc_mode)
         M_IDLE: plain_char(c);
         M_ESC: escape_letter(c);
         M_OCT: begin
            if (is_octal(c)) begin
               add_digit(h, 3);
               if (ndig >= 3) emit_value();
            end else begin
               flush_escape();
               plain_char(c);
            end
         end
         M_HEX2, M_HEX4: begin
            if (ndig == 0 && c == CH_LBRACE) begin
               esc_mode = M_XBRACE;
            end else if (h >= 0) begin
               add_digit(h, 4);
               if (ndig >= (esc_mode == M_HEX4 ? 4 : 2)) emit_value();
            end else begin
               flush_escape();
               plain_char(c);
            end
         end
         M_XBRACE: begin
            if (h >= 0 && ndig < EXT_HEX_DIGITS) begin
               add_digit(h, 4);
            end else if (c == CH_RBRACE) begin
               if (ndig == 0) begin
                  reset_escape();
                  expect_result(CH_X_LO, ST_EMPTY, 1'b0);
               end else begin
                  emit_value();
               end
            end else begin
               flush_escape();
               plain_char(c);
            end
         end
         M_OFIRST: begin
            if (c == CH_LBRACE) begin
               esc_mode = M_OBRACE;
            end else begin
               flush_escape();
               plain_char(c);
            end
         end
         M_OBRACE: begin
            if (is_octal(c) && ndig < EXT_OCT_DIGITS) begin
               add_digit(h, 3);
            end else if (c == CH_RBRACE) begin
               if (ndig == 0) begin
                  reset_escape();
                  expect_result(CH_O_LO, ST_EMPTY, 1'b0);
               end else begin
                  emit_value();
               end
            end else begin
               flush_escape();
               plain_char(c);
            end
         end
         default: begin
            reset_escape();
            plain_char(c);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         reset_escape();
         decoded_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) decode_request(req_ch.char_in, req_ch.end_mark);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.byte_out = rsp_ch.byte_out;
            got.status   = rsp_ch.status;
            got.last_out = rsp_ch.last_out;
            if (decoded_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected result byte %h status %0d last %b",
                           $realtime, got.byte_out, got.status, got.last_out);
            end else begin
               want = decoded_q.pop_front();
               if (got.byte_out !== want.byte_out || got.status !== want.status ||
                   got.last_out !== want.last_out) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: wrong result: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                              $realtime, want.byte_out, want.status, want.last_out,
                              got.byte_out, got.status, got.last_out);
               end
            end
         end
      end
      pending    <= decoded_q.size();
      fail_count <= errors;
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for the escape decoder: clock, reset, request and result drivers, verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sed_pkg::*;

   typedef struct packed {
      logic       end_mark;
      logic [7:0] ch;
   } src_char_type;

   localparam int RANDOM_CHARS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PCT     = 22;
   localparam int HOLD_AT      = 1000;
   localparam int HOLD_CYCLES  = 400;
   localparam int BUSY_FIRST   = 500;
   localparam int BUSY_LAST    = 800;

   logic         clock;
   logic         reset;
   int           cycle_count = 0;
   int           fail_count;
   int           pending;
   int           sent = 0;
   src_char_type char_q[$];

   sed_req_if req_if ();
   sed_rsp_if rsp_if ();

   string_escape_decoder_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   decode_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("string_escape_decoder_top: mismatch");
         $finish;
      end
   end

   // result side: random stalls, a quiet window while the sender runs without gaps,
   // and one long hold-off while requests keep coming
   initial begin
      int hold_left = 0;
      bit hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (sent >= BUSY_FIRST && sent < BUSY_LAST) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic add_char(input logic [7:0] c);
      src_char_type it;
      it.end_mark = 1'b0;
      it.ch       = c;
      char_q.push_back(it);
   endtask

   // terminator; char_in carries junk that must be ignored
   task automatic add_end();
      src_char_type it;
      it.end_mark = 1'b1;
      it.ch       = 8'($urandom_range(255));
      char_q.push_back(it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   function automatic logic [7:0] rand_hex();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   function automatic logic [7:0] rand_oct();
      return 8'h30 + 8'($urandom_range(7));
   endfunction

   // what follows a numeric escape: nothing, a terminator, or any byte
   task automatic add_tail();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) add_end();
      else if (pick < 55) add_char(8'($urandom_range(255)));
   endtask

   task automatic add_random_sequence();
      int    kind;
      int    n;
      string letters;
      letters = "abfnrtve\"?'\\";
      kind = $urandom_range(99);
      if (kind < 20) begin
         add_char(8'($urandom_range(255)));
      end else if (kind < 30) begin
         add_char(CH_BSL);
         add_char(letters[$urandom_range(letters.len() - 1)]);
      end else if (kind < 42) begin
         add_char(CH_BSL);
         n = $urandom_range(1, 4);
         repeat (n) add_char(rand_oct());
         add_tail();
      end else if (kind < 54) begin
         add_char(CH_BSL);
         add_char(CH_X_LO);
         n = $urandom_range(0, 3);
         repeat (n) add_char(rand_hex());
         add_tail();
      end else if (kind < 62) begin
         add_char(CH_BSL);
         add_char(CH_X_UP);
         n = $urandom_range(0, 5);
         repeat (n) add_char(rand_hex());
         add_tail();
      end else if (kind < 72) begin
         add_char(CH_BSL);
         add_char($urandom_range(1) ? CH_X_LO : CH_X_UP);
         add_char(CH_LBRACE);
         n = $urandom_range(0, 19);
         repeat (n) add_char(rand_hex());
         if ($urandom_range(99) < 65) add_char(CH_RBRACE);
         else add_tail();
      end else if (kind < 82) begin
         add_char(CH_BSL);
         add_char(CH_O_LO);
         add_char(CH_LBRACE);
         n = $urandom_range(0, 18);
         repeat (n) add_char(rand_oct());
         n = $urandom_range(99);
         if (n < 65) add_char(CH_RBRACE);
         else if (n < 75) add_char($urandom_range(1) ? "8" : "9");
         else add_tail();
      end else if (kind < 86) begin
         add_char(CH_BSL);
         add_char(CH_O_LO);
         add_char(8'($urandom_range(255)));
      end else if (kind < 92) begin
         add_char(CH_BSL);
         add_char(8'($urandom_range(255)));
      end else if (kind < 95) begin
         add_char(CH_BSL);
         add_end();
      end else begin
         add_end();
      end
   endtask

   task automatic send_item(input src_char_type it, input bit may_idle);
      while (may_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.char_in  <= it.ch;
      req_if.end_mark <= it.end_mark;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.char_in  = 8'h00;
      req_if.end_mark = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_char(8'h00);                   // NUL outside an escape is data
      add_text("\\e");
      add_text("\\777");                 // octal value truncated to 8 bits
      add_text("\\xg");                  // hex with no digits, then g itself
      add_text("\\o{}");
      add_text("\\oZ");                  // bare o
      add_text("\\u");                   // unknown escape
      add_text("\\x{1");
      add_end();                         // terminator closes an open brace
      add_char(CH_BSL);
      add_end();                         // trailing backslash
      while (char_q.size() != 0) send_item(char_q.pop_front(), 1'b1);
      wait_results_drained();

      while (sent < RANDOM_CHARS) begin
         if (char_q.size() == 0) add_random_sequence();
         send_item(char_q.pop_front(), !(sent >= BUSY_FIRST && sent < BUSY_LAST));
         sent++;
         if (sent == 300) wait_results_drained();
      end
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("string_escape_decoder_top: match");
      end else begin
         $display("string_escape_decoder_top: mismatch");
      end
      $finish;
   end

endmodule
